// ===== rtl/mmp_pkg.sv =====
// Shared constants, types and codes of the modular matrix power unit.
package mmp_pkg;

  localparam int unsigned DIM_DEF        = 8;
  localparam int unsigned VALUE_BITS_DEF = 30;
  localparam int unsigned EXP_BITS_DEF   = 40;
  localparam int unsigned POS_BITS       = 3;
  localparam logic [63:0] MOD_RESET      = 64'd1000000000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_RED,
    ST_PROD_RD,
    ST_PROD_MUL,
    ST_PROD_ACC,
    ST_PROD_GO,
    ST_PROD_RED,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_e;

  typedef enum logic {
    KIND_MUL,
    KIND_SQR
  } kind_e;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic acc_en;
  } dot_ctrl_t;

endpackage

// ===== rtl/modular_matrix_power_unit.sv =====
// Modular matrix power unit: top level with sequencer and matrix memories.
//
// A load beat (op 0) reduces value modulo the modulus bit-serially and writes one base
// entry; the reduction works on ACC_W = 2*VALUE_BITS + clog2(DIM) + 1 bits (64 by
// default). A start beat (op 1) raises the base to exponent by square-and-multiply; each
// matrix product is paced by the one-bit-per-cycle modular reduction of each dot product,
// and a 40-bit exponent needs up to 79 products. The DIM*DIM result beats follow in
// row-major order, each one registered only after the previous one is taken. Input stall
// stays high until the last result beat is taken. The base matrix is all zeros after reset.
module modular_matrix_power_unit #(
  parameter int unsigned DIM        = mmp_pkg::DIM_DEF,
  parameter int unsigned VALUE_BITS = mmp_pkg::VALUE_BITS_DEF,
  parameter int unsigned EXP_BITS   = mmp_pkg::EXP_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [VALUE_BITS-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [mmp_pkg::POS_BITS-1:0]  row_i,
  input  logic [mmp_pkg::POS_BITS-1:0]  col_i,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  logic [EXP_BITS-1:0]           exponent_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mmp_pkg::POS_BITS-1:0]  row_res_o,
  output logic [mmp_pkg::POS_BITS-1:0]  col_res_o,
  output logic [VALUE_BITS-1:0]         value_res_o,
  output logic                          last_o
);
  import mmp_pkg::*;

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned CW    = $clog2(DIM);
  localparam int unsigned IDX_W = $clog2(CELLS);
  localparam int unsigned ACC_W = 2 * VALUE_BITS + $clog2(DIM) + 1;
  localparam logic [CW-1:0] LAST_POS = CW'(DIM - 1);

  function automatic logic [IDX_W-1:0] cell_addr(input logic [CW-1:0] r,
                                                 input logic [CW-1:0] c);
    logic [2*IDX_W-1:0] full;
    full = (2*IDX_W)'(r) * (2*IDX_W)'(DIM) + (2*IDX_W)'(c);
    return full[IDX_W-1:0];
  endfunction

  state_e state_q, state_d;
  kind_e  kind_q;

  logic [VALUE_BITS-1:0] modulus_q, eff_mod;
  logic [EXP_BITS-1:0]   exp_q;
  logic [CW-1:0]         i_q, j_q, k_q;
  logic                  pbank_q, sbank_q, pow_ident_q, scr_base_q;
  logic [CELLS-1:0]      base_vld_q;

  logic [VALUE_BITS-1:0] base_mem [CELLS];
  logic [VALUE_BITS-1:0] scr_mem  [2**(IDX_W+1)];
  logic [VALUE_BITS-1:0] pow_mem  [2**(IDX_W+1)];

  logic [VALUE_BITS-1:0] base_a_q, base_b_q, scr_a_q, scr_b_q, pow_a_q;
  logic                  base_a_vld_q, base_b_vld_q, ident_q;

  logic [CW-1:0]         a_col;
  logic [IDX_W-1:0]      a_addr, b_addr, w_addr, ld_addr;
  logic [IDX_W-1:0]      ld_addr_q;
  logic                  in_acc, out_acc, ld_ok, k_last, entry_last, red_done;
  logic [VALUE_BITS-1:0] rem, a_val, b_val, pow_val;
  logic [ACC_W-1:0]      acc, red_x;
  logic                  red_start;
  dot_ctrl_t             dctl;

  logic [VALUE_BITS-1:0] out_value_q;
  logic [POS_BITS-1:0]   out_row_q, out_col_q;
  logic                  out_valid_q, out_last_q;

  assign eff_mod    = (modulus_q < VALUE_BITS'(2)) ? VALUE_BITS'(2) : modulus_q;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_acc    = out_valid_q && !out_stall_i;
  assign ld_ok      = ({1'b0, row_i} < (POS_BITS+1)'(DIM)) &&
                      ({1'b0, col_i} < (POS_BITS+1)'(DIM));
  assign ld_addr    = cell_addr(CW'(row_i), CW'(col_i));
  assign k_last     = (k_q == LAST_POS);
  assign entry_last = (i_q == LAST_POS) && (j_q == LAST_POS);

  assign a_col  = (state_q == ST_PROD_RD) ? k_q : j_q;
  assign a_addr = cell_addr(i_q, a_col);
  assign b_addr = cell_addr(k_q, j_q);
  assign w_addr = cell_addr(i_q, j_q);

  // operand selection after the registered memory reads
  assign pow_val = pow_ident_q ? VALUE_BITS'(ident_q) : pow_a_q;
  always_comb begin
    if (scr_base_q) begin
      b_val = base_b_vld_q ? base_b_q : '0;
    end else begin
      b_val = scr_b_q;
    end
    if (kind_q == KIND_MUL) begin
      a_val = pow_val;
    end else if (scr_base_q) begin
      a_val = base_a_vld_q ? base_a_q : '0;
    end else begin
      a_val = scr_a_q;
    end
  end

  assign dctl.clear  = (state_q == ST_PROD_RD) && (k_q == '0);
  assign dctl.mul_en = (state_q == ST_PROD_MUL);
  assign dctl.acc_en = (state_q == ST_PROD_ACC);

  assign red_start = (state_q == ST_PROD_GO) || (in_acc && op_i == OP_LOAD && ld_ok);
  assign red_x     = (state_q == ST_IDLE) ? ACC_W'(value_i) : acc;

  mmp_dot #(
    .VALUE_BITS(VALUE_BITS),
    .ACC_W     (ACC_W)
  ) u_dot (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(dctl),
    .a_i   (a_val),
    .b_i   (b_val),
    .acc_o (acc)
  );

  mmp_reduce #(
    .VALUE_BITS(VALUE_BITS),
    .ACC_W     (ACC_W)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(red_start),
    .x_i    (red_x),
    .m_i    (eff_mod),
    .done_o (red_done),
    .rem_o  (rem)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_i == OP_START) begin
            state_d = (exponent_i == '0) ? ST_EMIT_RD : ST_PROD_RD;
          end else if (ld_ok) begin
            state_d = ST_LOAD_RED;
          end
        end
      end
      ST_LOAD_RED: if (red_done) state_d = ST_IDLE;
      ST_PROD_RD:  state_d = ST_PROD_MUL;
      ST_PROD_MUL: state_d = ST_PROD_ACC;
      ST_PROD_ACC: state_d = k_last ? ST_PROD_GO : ST_PROD_RD;
      ST_PROD_GO:  state_d = ST_PROD_RED;
      ST_PROD_RED: begin
        if (red_done) begin
          if (!entry_last || kind_q == KIND_SQR || exp_q[EXP_BITS-1:1] != '0) begin
            state_d = ST_PROD_RD;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_EMIT_RD:   state_d = ST_EMIT_LD;
      ST_EMIT_LD:   state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_acc) state_d = out_last_q ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q   <= MOD_RESET[VALUE_BITS-1:0];
      base_vld_q  <= '0;
      exp_q       <= '0;
      kind_q      <= KIND_SQR;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pbank_q     <= 1'b0;
      sbank_q     <= 1'b0;
      pow_ident_q <= 1'b1;
      scr_base_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) modulus_q <= cfg_data_i;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && op_i == OP_START) begin
            exp_q       <= exponent_i;
            kind_q      <= exponent_i[0] ? KIND_MUL : KIND_SQR;
            i_q         <= '0;
            j_q         <= '0;
            k_q         <= '0;
            pow_ident_q <= 1'b1;
            scr_base_q  <= 1'b1;
          end
        end
        ST_LOAD_RED: begin
          if (red_done) base_vld_q[ld_addr_q] <= 1'b1;
        end
        ST_PROD_ACC: begin
          k_q <= k_last ? '0 : k_q + 1'b1;
        end
        ST_PROD_RED: begin
          if (red_done) begin
            if (entry_last) begin
              i_q <= '0;
              j_q <= '0;
              if (kind_q == KIND_MUL) begin
                pbank_q     <= ~pbank_q;
                pow_ident_q <= 1'b0;
                kind_q      <= KIND_SQR;
                if (exp_q[EXP_BITS-1:1] == '0) exp_q <= '0;
              end else begin
                sbank_q    <= ~sbank_q;
                scr_base_q <= 1'b0;
                exp_q      <= exp_q >> 1;
                kind_q     <= exp_q[1] ? KIND_MUL : KIND_SQR;
              end
            end else if (j_q == LAST_POS) begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        ST_EMIT_LD: begin
          out_valid_q <= 1'b1;
        end
        ST_EMIT_WAIT: begin
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              i_q <= '0;
              j_q <= '0;
            end else if (j_q == LAST_POS) begin
              j_q <= '0;
              i_q <= i_q + 1'b1;
            end else begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // hold the load address while the value is reduced
  always_ff @(posedge clk_i) begin
    if (in_acc) ld_addr_q <= ld_addr;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD_RED && red_done) base_mem[ld_addr_q] <= rem;
    base_a_q     <= base_mem[a_addr];
    base_b_q     <= base_mem[b_addr];
    base_a_vld_q <= base_vld_q[a_addr];
    base_b_vld_q <= base_vld_q[b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PROD_RED && red_done && kind_q == KIND_SQR) begin
      scr_mem[{~sbank_q, w_addr}] <= rem;
    end
    scr_a_q <= scr_mem[{sbank_q, a_addr}];
    scr_b_q <= scr_mem[{sbank_q, b_addr}];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PROD_RED && red_done && kind_q == KIND_MUL) begin
      pow_mem[{~pbank_q, w_addr}] <= rem;
    end
    pow_a_q <= pow_mem[{pbank_q, a_addr}];
    ident_q <= (i_q == a_col);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT_LD) begin
      out_value_q <= pow_val;
      out_row_q   <= POS_BITS'(i_q);
      out_col_q   <= POS_BITS'(j_q);
      out_last_q  <= entry_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_res_o   = out_row_q;
  assign col_res_o   = out_col_q;
  assign value_res_o = out_value_q;
  assign last_o      = out_last_q;

endmodule

// ===== rtl/mmp_reduce.sv =====
// Bit-serial restoring reduction of a wide value modulo a runtime modulus.
module mmp_reduce #(
  parameter int unsigned VALUE_BITS = mmp_pkg::VALUE_BITS_DEF,
  parameter int unsigned ACC_W      = 2 * mmp_pkg::VALUE_BITS_DEF + 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [ACC_W-1:0]      x_i,
  input  logic [VALUE_BITS-1:0] m_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] rem_o
);
  import mmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(ACC_W + 1);

  logic [ACC_W-1:0]      sh_q;
  logic [VALUE_BITS-1:0] rem_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   m_ext;

  assign m_ext = {1'b0, m_i};
  assign trial = {rem_q, sh_q[ACC_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ACC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift in one dividend bit a cycle, subtract the modulus when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= x_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q <= {sh_q[ACC_W-2:0], 1'b0};
      if (trial >= m_ext) begin
        rem_q <= VALUE_BITS'(trial - m_ext);
      end else begin
        rem_q <= VALUE_BITS'(trial);
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/mmp_dot.sv =====
// Multiply and exact accumulate of one row-by-column dot product.
module mmp_dot #(
  parameter int unsigned VALUE_BITS = mmp_pkg::VALUE_BITS_DEF,
  parameter int unsigned ACC_W      = 2 * mmp_pkg::VALUE_BITS_DEF + 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mmp_pkg::dot_ctrl_t        ctrl_i,
  input  logic [VALUE_BITS-1:0]     a_i,
  input  logic [VALUE_BITS-1:0]     b_i,
  output logic [ACC_W-1:0]          acc_o
);
  import mmp_pkg::*;

  logic [2*VALUE_BITS-1:0] prod_q;
  logic [ACC_W-1:0]        acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  assign acc_o = acc_q;

endmodule

// ===== sim/tb_modular_matrix_power_unit.sv =====
// Testbench for the modular matrix power unit: directed and random beats, self-checking.
`timescale 1ns / 100ps

module tb_modular_matrix_power_unit;
  import mmp_pkg::*;

  localparam int unsigned DIM        = DIM_DEF;
  localparam int unsigned VALUE_BITS = VALUE_BITS_DEF;
  localparam int unsigned EXP_BITS   = EXP_BITS_DEF;
  localparam int unsigned ENTRIES    = DIM * DIM;
  localparam int unsigned IDLE_LIMIT = 2000000;
  localparam int unsigned SETTLE     = 150;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  localparam logic [EXP_BITS-1:0]   EXP_MAX   = '1;

  typedef struct {
    logic [POS_BITS-1:0]   row;
    logic [POS_BITS-1:0]   col;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } entry_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [VALUE_BITS-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  op_i;
  logic [POS_BITS-1:0]   row_i;
  logic [POS_BITS-1:0]   col_i;
  logic [VALUE_BITS-1:0] value_i;
  logic [EXP_BITS-1:0]   exponent_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [POS_BITS-1:0]   row_res_o;
  logic [POS_BITS-1:0]   col_res_o;
  logic [VALUE_BITS-1:0] value_res_o;
  logic                  last_o;

  modular_matrix_power_unit #(
    .DIM(DIM), .VALUE_BITS(VALUE_BITS), .EXP_BITS(EXP_BITS)
  ) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .op_i(op_i), .row_i(row_i), .col_i(col_i), .value_i(value_i), .exponent_i(exponent_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .row_res_o(row_res_o), .col_res_o(col_res_o), .value_res_o(value_res_o), .last_o(last_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Predictor state
  longint unsigned mod_reg;
  longint unsigned base_mat[ENTRIES];
  entry_t          pending_entries[$];
  int              errors;

  // Stimulus shaping
  int burst_left;
  int max_gap;
  int stall_pct;
  int hold_req;
  int hold_cnt;
  int idle_cycles;

  function automatic longint unsigned eff_mod();
    return (mod_reg < 2) ? 64'd2 : mod_reg;
  endfunction

  function automatic void mat_product(output longint unsigned dst[ENTRIES],
                                      input longint unsigned a[ENTRIES],
                                      input longint unsigned b[ENTRIES]);
    longint unsigned md;
    longint unsigned acc;
    md = eff_mod();
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++) begin
        acc = 0;
        for (int k = 0; k < DIM; k++) acc = (acc + a[i*DIM+k] * b[k*DIM+j]) % md;
        dst[i*DIM+j] = acc;
      end
    end
  endfunction

  function automatic void predict_power(input logic [EXP_BITS-1:0] expo);
    longint unsigned power[ENTRIES];
    longint unsigned sq[ENTRIES];
    longint unsigned tmp[ENTRIES];
    logic [EXP_BITS-1:0] bits_left;
    entry_t e;
    for (int i = 0; i < ENTRIES; i++) begin
      power[i] = (i / DIM == i % DIM) ? 1 : 0;
      sq[i]    = base_mat[i];
    end
    bits_left = expo;
    while (bits_left != 0) begin
      if (bits_left[0]) begin
        mat_product(tmp, power, sq);
        power = tmp;
      end
      mat_product(tmp, sq, sq);
      sq = tmp;
      bits_left = bits_left >> 1;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      e.row   = POS_BITS'(i / DIM);
      e.col   = POS_BITS'(i % DIM);
      e.value = VALUE_BITS'(power[i]);
      e.last  = (i == ENTRIES - 1);
      pending_entries.push_back(e);
    end
  endfunction

  task automatic send_beat(input logic op, input logic [POS_BITS-1:0] r,
                           input logic [POS_BITS-1:0] c, input logic [VALUE_BITS-1:0] v,
                           input logic [EXP_BITS-1:0] expo);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    row_i      <= r;
    col_i      <= c;
    value_i    <= v;
    exponent_i <= expo;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (op == OP_LOAD) base_mat[r*DIM+c] = longint'(v) % eff_mod();
    else predict_power(expo);
  endtask

  task automatic load_entry(input int r, input int c, input logic [VALUE_BITS-1:0] v);
    send_beat(OP_LOAD, POS_BITS'(r), POS_BITS'(c), v, EXP_BITS'($urandom));
  endtask

  task automatic start_power(input logic [EXP_BITS-1:0] expo);
    send_beat(OP_START, POS_BITS'($urandom), POS_BITS'($urandom), VALUE_BITS'($urandom), expo);
  endtask

  // Hold the sender until every expected entry is back and the block is quiet.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_entries.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_modulus(input logic [VALUE_BITS-1:0] m);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mod_reg = m;
  endtask

  // Checker, receiver stall pattern and watchdog
  always @(posedge clk_i) begin
    entry_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_entries.size() == 0) begin
          $display("%0t: unexpected entry row %0d col %0d value %0d last %0b", $time,
                   row_res_o, col_res_o, value_res_o, last_o);
          errors++;
        end else begin
          e = pending_entries.pop_front();
          if (row_res_o !== e.row || col_res_o !== e.col || value_res_o !== e.value ||
              last_o !== e.last) begin
            $display("%0t: expected row %0d col %0d value %0d last %0b", $time,
                     e.row, e.col, e.value, e.last);
            $display("%0t:   actual row %0d col %0d value %0d last %0b", $time,
                     row_res_o, col_res_o, value_res_o, last_o);
            errors++;
          end
        end
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Reset leaves a zero base: any power but zero is all zeros.
  task automatic test_reset_base();
    start_power('0);
    start_power(EXP_BITS'(5));
    drain();
  endtask

  task automatic test_load_extremes();
    load_entry(0, 0, VALUE_MAX);
    load_entry(7, 7, '0);
    load_entry(0, 7, VALUE_BITS'(999999999));
    load_entry(7, 0, VALUE_BITS'(1000000000));
    load_entry(3, 4, VALUE_BITS'($urandom));
    start_power(EXP_BITS'(1));
    start_power(EXP_BITS'(2));
    start_power(EXP_BITS'(3));
    drain();
  endtask

  task automatic test_modulus_extremes();
    write_modulus(VALUE_BITS'(2));
    load_entry(1, 1, VALUE_BITS'(3));
    load_entry(1, 2, VALUE_MAX);
    start_power(EXP_BITS'(3));
    drain();
    write_modulus('0);
    load_entry(2, 2, VALUE_BITS'(5));
    start_power(EXP_BITS'(2));
    drain();
    write_modulus(VALUE_BITS'(1));
    start_power(EXP_BITS'(1));
    drain();
    write_modulus(VALUE_MAX);
    load_entry(0, 0, VALUE_MAX);
    load_entry(0, 1, VALUE_MAX - 1);
    start_power(EXP_MAX);
    drain();
  endtask

  // Entries stored under a large modulus are used as stored under a smaller one.
  task automatic test_modulus_change();
    load_entry(5, 5, VALUE_MAX - 2);
    load_entry(5, 6, VALUE_BITS'(123456789));
    load_entry(6, 5, VALUE_BITS'(987654321));
    drain();
    write_modulus(VALUE_BITS'(1000));
    start_power(EXP_BITS'(2));
    drain();
  endtask

  // Stall the output for a long stretch while loads keep arriving behind a start.
  task automatic test_output_backpressure();
    hold_req = 1500;
    max_gap  = 0;
    start_power('0);
    load_entry(4, 4, VALUE_BITS'(77));
    load_entry(4, 3, VALUE_BITS'(11));
    start_power(EXP_BITS'(1));
    drain();
    max_gap = 6;
  endtask

  task automatic test_random();
    logic [VALUE_BITS-1:0] mods[4];
    mods[0] = MOD_RESET[VALUE_BITS-1:0];
    mods[1] = VALUE_BITS'($urandom_range(2, 50));
    mods[2] = VALUE_BITS'($urandom);
    mods[3] = VALUE_MAX - VALUE_BITS'($urandom_range(0, 1000));
    for (int p = 0; p < 4; p++) begin
      write_modulus(mods[p]);
      stall_pct = (p == 2) ? 0 : $urandom_range(10, 60);
      max_gap   = (p == 2) ? 0 : $urandom_range(2, 10);
      for (int n = 0; n < 18; n++) begin
        if ($urandom_range(0, 99) < 7) start_power(EXP_BITS'($urandom_range(0, 31)));
        else load_entry($urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                        ($urandom_range(0, 9) == 0) ? VALUE_MAX : VALUE_BITS'($urandom));
      end
      start_power(EXP_BITS'($urandom_range(1, 15)));
      drain();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    op_i        = OP_LOAD;
    row_i       = '0;
    col_i       = '0;
    value_i     = '0;
    exponent_i  = '0;
    out_stall_i = 1'b0;
    errors      = 0;
    burst_left  = 0;
    max_gap     = 4;
    stall_pct   = 25;
    hold_req    = 0;
    hold_cnt    = 0;
    idle_cycles = 0;
    mod_reg     = MOD_RESET;
    foreach (base_mat[i]) base_mat[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_base();
    test_load_extremes();
    test_modulus_extremes();
    test_modulus_change();
    test_output_backpressure();
    test_random();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
